FILE: src/assert_macros.svh
// Assertion macros for the RTL files; only the top level includes them.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: src/scm_pkg.sv
// Shared types and constants of the spectral compression mask.
// No dependencies; used by the top level and scm_rdiv.
package scm_pkg;

    localparam int FFT_SIZE  = 4096;
    localparam int NUM_BINS  = FFT_SIZE / 2 + 1;
    localparam int LAST_BIN  = FFT_SIZE / 2;
    localparam int BIN_AW    = $clog2(NUM_BINS);
    localparam int MAG_W     = 28;
    localparam int ROOT_W    = 58;
    localparam int QUO_W     = 49;
    localparam int ROOT_STEPS = 28;
    localparam int DIV_STEPS  = 49;

    typedef logic [BIN_AW-1:0] t_addr;

    typedef enum logic [1:0] {
        REG_PEAK_DECAY = 2'd0,
        REG_RED_DECAY  = 2'd1,
        REG_EQ_ENABLE  = 2'd2,
        REG_EQ_PREAMP  = 2'd3
    } t_reg;

    typedef enum logic {
        OP_ROOT = 1'b0,
        OP_DIV  = 1'b1
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_rd_req;

endpackage

FILE: src/spectral_compression_mask.sv
// Top level of the spectral compression mask: sequencer, config registers, state.
// Depends on scm_pkg, scm_ram, scm_mul, scm_rdiv and assert_macros.svh.
//
//  channel  direction  handshake          payload
//  input    in         i_valid / o_stall  i_bin_real, i_bin_imag, i_bin_index,
//                                         i_comp_gain, i_eq_gain
//  output   out        o_valid / i_stall  o_mask_value, o_reduction_level,
//                                         o_running_peak, o_frame_done
//  config   in         APB write/read     psel, penable, pwrite, paddr, pwdata
//
// A new item is taken only after the previous one has left the sequencer for the
// output register; the reciprocal branch and, when enabled, the equalizer add steps.
// The bit-serial square root (28 steps) and the 49-step divider of the shared
// root/divide unit take most of the time per item.
// After reset the per-bin reduction store is cleared, one entry a cycle, all
// 2049 entries; no item is taken meanwhile, config writes are.
// A finished result waits in the output register; the next item may be taken
// and worked on while it waits, and only its own delivery holds for the slot.
`include "assert_macros.svh"

module spectral_compression_mask (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [23:0] i_bin_real,
    input  logic [23:0] i_bin_imag,
    input  logic [11:0] i_bin_index,
    input  logic [31:0] i_comp_gain,
    input  logic [31:0] i_eq_gain,
    // result items
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_mask_value,
    output logic [31:0] o_reduction_level,
    output logic [31:0] o_running_peak,
    output logic        o_frame_done,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    typedef enum logic [17:0] {
        S_CLR    = 18'b000000000000000001,
        S_IDLE   = 18'b000000000000000010,
        S_SQRE   = 18'b000000000000000100,
        S_SQIM   = 18'b000000000000001000,
        S_SQSUM  = 18'b000000000000010000,
        S_ROOT   = 18'b000000000000100000,
        S_MULP   = 18'b000000000001000000,
        S_TEST   = 18'b000000000010000000,
        S_DIV    = 18'b000000000100000000,
        S_PEAK   = 18'b000000001000000000,
        S_PKUPD  = 18'b000000010000000000,
        S_RED    = 18'b000000100000000000,
        S_REDUPD = 18'b000001000000000000,
        S_EQ1    = 18'b000010000000000000,
        S_EQ2    = 18'b000100000000000000,
        S_EQ3    = 18'b001000000000000000,
        S_EQ4    = 18'b010000000000000000,
        S_OUT    = 18'b100000000000000000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [31:0] r_peak_decay, r_red_decay, r_eq_preamp;
    logic        r_eq_enable;
    logic        w_cfg_we;
    scm_pkg::t_reg w_reg;

    // item registers
    logic [23:0] r_re, r_im;
    logic [11:0] r_idx;
    logic [31:0] r_comp, r_eq;
    logic        r_idx_ok, n_idx_ok;

    // working registers
    logic [47:0]                 r_acc;
    logic [scm_pkg::MAG_W-1:0]   r_mag;
    logic [31:0]                 r_test, r_mask, r_peak, r_red, r_omask;
    logic [7:0]                  r_th;
    logic [63:0]                 r_lo;
    scm_pkg::t_addr              r_clr_cnt;

    // output register
    logic        r_ovalid;
    logic [31:0] r_out_mask, r_out_red, r_out_peak;
    logic        r_out_done;

    // shared units
    logic [31:0]                 w_ma, w_mb;
    logic [63:0]                 w_prod;
    scm_pkg::t_rd_req            w_req;
    logic [55:0]                 w_radicand;
    logic                        w_rd_done;
    logic [scm_pkg::QUO_W-1:0]   w_rd_res;

    // memory ports
    logic                        w_we;
    scm_pkg::t_addr              w_waddr, w_raddr;
    logic [31:0]                 w_wdata, w_rdata;

    logic [23:0] w_abs_re, w_abs_im;
    logic [47:0] w_sum;
    logic [31:0] w_diff, w_red_new;
    logic [71:0] w_full;
    logic        w_accept, w_out_free;

    assign w_abs_re = r_re[23] ? (~r_re + 24'd1) : r_re;
    assign w_abs_im = r_im[23] ? (~r_im + 24'd1) : r_im;
    assign w_sum    = r_acc + w_prod[47:0];
    assign w_radicand = {w_sum, 8'd0};
    assign w_diff   = (r_comp > r_mask) ? (r_comp - r_mask) : 32'd0;
    assign w_red_new = (w_diff > w_rdata) ? w_diff : w_prod[63:32];
    assign w_full   = {w_prod[39:0], 32'd0} + {8'd0, r_lo};

    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_ovalid || !i_stall;
    assign o_stall    = (r_state != S_IDLE);

    // configuration port
    assign pready   = 1'b1;
    assign w_reg    = scm_pkg::t_reg'(paddr[3:2]);
    assign w_cfg_we = psel && penable && pwrite;

    always_comb begin
        case (w_reg)
            scm_pkg::REG_PEAK_DECAY: prdata = r_peak_decay;
            scm_pkg::REG_RED_DECAY:  prdata = r_red_decay;
            scm_pkg::REG_EQ_ENABLE:  prdata = {31'd0, r_eq_enable};
            scm_pkg::REG_EQ_PREAMP:  prdata = r_eq_preamp;
            default:                 prdata = 32'd0;
        endcase
    end

    // operand select for the shared multiplier
    always_comb begin
        case (r_state)
            S_SQRE:  begin w_ma = 32'(w_abs_re); w_mb = 32'(w_abs_re); end
            S_SQIM:  begin w_ma = 32'(w_abs_im); w_mb = 32'(w_abs_im); end
            S_MULP:  begin w_ma = r_comp; w_mb = 32'(r_mag); end
            S_PEAK:  begin w_ma = r_peak; w_mb = r_peak_decay; end
            S_RED:   begin w_ma = w_rdata; w_mb = r_red_decay; end
            S_EQ1:   begin w_ma = r_mask; w_mb = r_eq_preamp; end
            S_EQ2:   begin w_ma = w_prod[55:24]; w_mb = r_eq; end
            S_EQ3:   begin w_ma = 32'(r_th); w_mb = r_eq; end
            default: begin w_ma = 32'd0; w_mb = 32'd0; end
        endcase
    end

    always_comb begin
        w_req.start = 1'b0;
        w_req.op    = scm_pkg::OP_ROOT;
        if (r_state == S_SQSUM) begin
            w_req.start = 1'b1;
        end else if (r_state == S_TEST && w_prod > 64'h0001_0000_0000_0000) begin
            w_req.start = 1'b1;
            w_req.op    = scm_pkg::OP_DIV;
        end
    end

    // memory: clear sweep, then read-modify-write of one entry per in-range item
    assign w_raddr = r_idx_ok ? scm_pkg::t_addr'(r_idx) : '0;
    always_comb begin
        if (r_state == S_CLR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_cnt;
            w_wdata = 32'd0;
        end else begin
            w_we    = (r_state == S_REDUPD) && r_idx_ok;
            w_waddr = w_raddr;
            w_wdata = w_red_new;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_idx_ok = r_idx_ok;
        case (r_state)
            S_CLR: begin
                if (r_clr_cnt == scm_pkg::t_addr'(scm_pkg::NUM_BINS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state  = S_SQRE;
                    n_idx_ok = (32'(i_bin_index) <= scm_pkg::LAST_BIN);
                end
            end
            S_SQRE:  n_state = S_SQIM;
            S_SQIM:  n_state = S_SQSUM;
            S_SQSUM: n_state = S_ROOT;
            S_ROOT:  if (w_rd_done) n_state = S_MULP;
            S_MULP:  n_state = S_TEST;
            S_TEST:  n_state = w_req.start ? S_DIV : S_PEAK;
            S_DIV:   if (w_rd_done) n_state = S_PEAK;
            S_PEAK:  n_state = S_PKUPD;
            S_PKUPD: n_state = S_RED;
            S_RED:   n_state = S_REDUPD;
            S_REDUPD: n_state = r_eq_enable ? S_EQ1 : S_OUT;
            S_EQ1:   n_state = S_EQ2;
            S_EQ2:   n_state = S_EQ3;
            S_EQ3:   n_state = S_EQ4;
            S_EQ4:   n_state = S_OUT;
            S_OUT:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr_cnt    <= '0;
            r_idx_ok     <= 1'b0;
            r_peak       <= 32'd0;
            r_ovalid     <= 1'b0;
            r_peak_decay <= 32'hFFFF_FFFF;
            r_red_decay  <= 32'hFFFF_FFFF;
            r_eq_enable  <= 1'b0;
            r_eq_preamp  <= 32'h0100_0000;
        end else begin
            r_state  <= n_state;
            r_idx_ok <= n_idx_ok;
            if (r_state == S_CLR) begin
                r_clr_cnt <= r_clr_cnt + scm_pkg::t_addr'(1);
            end
            if (w_cfg_we) begin
                case (w_reg)
                    scm_pkg::REG_PEAK_DECAY: r_peak_decay <= pwdata;
                    scm_pkg::REG_RED_DECAY:  r_red_decay  <= pwdata;
                    scm_pkg::REG_EQ_ENABLE:  r_eq_enable  <= pwdata[0];
                    scm_pkg::REG_EQ_PREAMP:  r_eq_preamp  <= pwdata;
                    default: ;
                endcase
            end
            // peak jumps up, otherwise decays
            if (r_state == S_PKUPD) begin
                r_peak <= (r_test > r_peak) ? r_test : w_prod[63:32];
            end
            // load a finished result when the slot frees, else drop it once taken
            if (r_state == S_OUT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_re   <= i_bin_real;
            r_im   <= i_bin_imag;
            r_idx  <= i_bin_index;
            r_comp <= i_comp_gain;
            r_eq   <= i_eq_gain;
        end
        case (r_state)
            S_SQIM: r_acc <= w_prod[47:0];
            S_ROOT: if (w_rd_done) r_mag <= w_rd_res[scm_pkg::MAG_W-1:0];
            S_TEST: begin
                r_test <= (w_prod[63:56] != 8'd0) ? 32'hFFFF_FFFF : w_prod[55:24];
                r_mask <= r_comp;
            end
            S_DIV: begin
                if (w_rd_done) begin
                    r_mask <= (w_rd_res[scm_pkg::QUO_W-1:32] != '0) ? 32'hFFFF_FFFF
                                                                   : w_rd_res[31:0];
                end
            end
            S_REDUPD: begin
                r_red   <= r_idx_ok ? w_red_new : 32'd0;
                r_omask <= r_mask;
            end
            S_EQ2:  r_th <= w_prod[63:56];
            S_EQ3:  r_lo <= w_prod;
            S_EQ4:  r_omask <= (w_full[71:56] != 16'd0) ? 32'hFFFF_FFFF : w_full[55:24];
            default: ;
        endcase
        if (r_state == S_OUT && w_out_free) begin
            r_out_mask <= r_omask;
            r_out_red  <= r_red;
            r_out_peak <= r_peak;
            r_out_done <= (32'(r_idx) == scm_pkg::LAST_BIN);
        end
    end

    assign o_valid           = r_ovalid;
    assign o_mask_value      = r_out_mask;
    assign o_reduction_level = r_out_red;
    assign o_running_peak    = r_out_peak;
    assign o_frame_done      = r_out_done;

    scm_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .o_prod (w_prod)
    );

    scm_rdiv u_rdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .i_radicand (w_radicand),
        .i_divisor  (r_mag),
        .o_done     (w_rd_done),
        .o_result   (w_rd_res)
    );

    scm_ram #(
        .WIDTH (32),
        .DEPTH (scm_pkg::NUM_BINS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    `ASSERT_CLK(a_busy_after_accept, w_accept |=> o_stall, "item taken while busy")
    `ASSERT_CLK(a_clear_blocks, (r_state == S_CLR) |-> o_stall, "item taken during clear")
    `ASSERT_CLK(a_out_loaded, (r_state == S_OUT && w_out_free) |=> o_valid, "result lost")
endmodule

FILE: src/scm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2049
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/scm_mul.sv
// Shared 32 x 32 unsigned multiplier with a registered product.
// Depends on nothing; operands are chosen by the sequencer in the top level.
module scm_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_prod
);
    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_prod = r_prod;
endmodule

FILE: src/scm_rdiv.sv
// Iterative square root and restoring divider (2^48 / divisor), one bit a cycle.
// Depends on scm_pkg.
module scm_rdiv (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  scm_pkg::t_rd_req                 i_req,
    input  logic [55:0]                      i_radicand,
    input  logic [scm_pkg::MAG_W-1:0]        i_divisor,
    output logic                             o_done,
    output logic [scm_pkg::QUO_W-1:0]        o_result
);
    logic                              r_busy, n_busy;
    logic                              r_done, n_done;
    scm_pkg::t_op                      r_op, n_op;
    logic [5:0]                        r_cnt, n_cnt;
    logic [scm_pkg::ROOT_W-1:0]        r_v, n_v;
    logic [scm_pkg::ROOT_W-1:0]        r_res, n_res;
    logic [scm_pkg::ROOT_W-1:0]        r_bit, n_bit;
    logic [scm_pkg::MAG_W:0]           r_rem, n_rem;
    logic [scm_pkg::QUO_W-1:0]         r_quo, n_quo;
    logic [scm_pkg::QUO_W-1:0]         r_dvd, n_dvd;
    logic [scm_pkg::MAG_W-1:0]         r_dvs, n_dvs;
    logic [scm_pkg::ROOT_W-1:0]        w_trial;
    logic [scm_pkg::MAG_W:0]           w_rem2;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_v    = r_v;
        n_res  = r_res;
        n_bit  = r_bit;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        w_trial = r_res + r_bit;
        w_rem2  = {r_rem[scm_pkg::MAG_W-1:0], r_dvd[scm_pkg::QUO_W-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_v    = scm_pkg::ROOT_W'(i_radicand);
            n_res  = '0;
            n_bit  = scm_pkg::ROOT_W'(1) << 54;
            n_rem  = '0;
            n_quo  = '0;
            n_dvd  = scm_pkg::QUO_W'(1) << 48;
            n_dvs  = i_divisor;
            n_cnt  = (i_req.op == scm_pkg::OP_ROOT) ? 6'(scm_pkg::ROOT_STEPS - 1)
                                                    : 6'(scm_pkg::DIV_STEPS - 1);
        end else if (r_busy) begin
            if (r_op == scm_pkg::OP_ROOT) begin
                if (r_v >= w_trial) begin
                    n_v   = r_v - w_trial;
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit = r_bit >> 2;
            end else begin
                // shift in the next dividend bit, subtract when it fits
                n_dvd = r_dvd << 1;
                if (w_rem2 >= {1'b0, r_dvs}) begin
                    n_rem = w_rem2 - {1'b0, r_dvs};
                    n_quo = {r_quo[scm_pkg::QUO_W-2:0], 1'b1};
                end else begin
                    n_rem = w_rem2;
                    n_quo = {r_quo[scm_pkg::QUO_W-2:0], 1'b0};
                end
            end
            if (r_cnt == 6'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_op  <= n_op;
        r_cnt <= n_cnt;
        r_v   <= n_v;
        r_res <= n_res;
        r_bit <= n_bit;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
    end

    assign o_done   = r_done;
    assign o_result = (r_op == scm_pkg::OP_ROOT) ? scm_pkg::QUO_W'(r_res) : r_quo;
endmodule
